// File: src/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants for the pressure and temperature compensation
// pipeline.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int DivBits = 64;

  localparam logic signed [33:0] TfOffset = 34'sd128000;
  localparam logic [20:0]        PBase    = 21'd1048576;
  localparam logic [11:0]        NumScale = 12'd3125;
  localparam logic [63:0]        P1Bias   = 64'h0000_8000_0000_0000;

  typedef enum logic [7:0] {
    RegTempCoef  = 8'd0,
    RegPressLow  = 8'd1,
    RegPressMid  = 8'd2,
    RegPressHigh = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } coef_t;

  typedef struct packed {
    logic [31:0] tf;
    logic [19:0] raw_pressure;
  } tf_t;

  typedef struct packed {
    logic [63:0] num;
    logic [30:0] den;
    logic        zero;
    logic [15:0] temp;
  } div_in_t;

  typedef struct packed {
    logic [63:0] dq;
    logic        neg;
    logic        zero;
    logic [15:0] temp;
  } div_out_t;

endpackage

// File: src/ptc_if.sv
// ----------------------------------------------------------------------------
// ptc channel interfaces
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface ptc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface ptc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] temperature_centidegrees;
  logic [31:0] pressure_q24_8;
  logic        pressure_valid;
  modport source (output valid, temperature_centidegrees, pressure_q24_8, pressure_valid,
                  input ready);
  modport sink   (input valid, temperature_centidegrees, pressure_q24_8, pressure_valid,
                  output ready);
endinterface

interface ptc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/ptc_temp.sv
// ----------------------------------------------------------------------------
// ptc_temp
// Three-stage 32-bit fine temperature computation.
// ----------------------------------------------------------------------------
module ptc_temp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  ptc_pkg::coef_t coef_i,
  input  logic           in_valid_i,
  input  logic [19:0]    raw_temperature_i,
  input  logic [19:0]    raw_pressure_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output ptc_pkg::tf_t   out_o
);
  import ptc_pkg::*;

  logic [2:0] vld_q;
  logic       ld1;

  logic signed [17:0] a_t;
  logic signed [16:0] d_t;
  logic signed [33:0] at2_d, at2_q;
  logic signed [33:0] dd_d, dd_q;
  logic [19:0]        rp1_q, rp2_q, rp3_q;

  logic signed [20:0] v1t_d, v1t_q;
  logic signed [19:0] v2a;
  logic signed [35:0] v2t3_d, v2t3_q;
  logic signed [31:0] tf_d, tf_q;

  // The first stage can take a request while the rest of the pipe is stalled.
  assign ld1        = en_i || !vld_q[0];
  assign in_ready_o = ld1;

  always_comb begin
    a_t    = $signed({1'b0, raw_temperature_i[19:3]}) - $signed({1'b0, coef_i.t1, 1'b0});
    d_t    = $signed({1'b0, raw_temperature_i[19:4]}) - $signed({1'b0, coef_i.t1});
    at2_d  = a_t * $signed(coef_i.t2);
    dd_d   = d_t * d_t;
    v1t_d  = $signed(at2_q[31:11]);
    v2a    = $signed(dd_q[31:12]);
    v2t3_d = v2a * $signed(coef_i.t3);
    tf_d   = v1t_q + $signed(v2t3_q[31:14]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld1) vld_q[0] <= in_valid_i;
      if (en_i) vld_q[2:1] <= vld_q[1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      at2_q <= at2_d;
      dd_q  <= dd_d;
      rp1_q <= raw_pressure_i;
    end
    if (en_i) begin
      v1t_q  <= v1t_d;
      v2t3_q <= v2t3_d;
      rp2_q  <= rp1_q;
      tf_q   <= tf_d;
      rp3_q  <= rp2_q;
    end
  end

  assign out_valid_o        = vld_q[2];
  assign out_o.tf           = tf_q;
  assign out_o.raw_pressure = rp3_q;

endmodule

// File: src/ptc_prep.sv
// ----------------------------------------------------------------------------
// ptc_prep
// Temperature output and 64-bit pressure dividend and 31-bit divisor, seven stages.
// ----------------------------------------------------------------------------
module ptc_prep (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  ptc_pkg::coef_t   coef_i,
  input  logic             in_valid_i,
  input  ptc_pkg::tf_t     in_i,
  output logic             out_valid_o,
  output ptc_pkg::div_in_t out_o
);
  import ptc_pkg::*;

  logic [6:0] vld_q;

  // Stage 4
  logic signed [33:0] v1p;
  logic signed [67:0] sqf;
  logic signed [49:0] m5_d, m2_d;
  logic [31:0]        t5;
  logic signed [23:0] tc;
  logic [15:0]        temp_d;
  logic [63:0]        s4_sq_q;
  logic [49:0]        s4_m5_q, s4_m2_q;
  logic [15:0]        temp_q [7];
  logic [19:0]        rp_q [4];

  // Stage 5
  logic signed [48:0] lo6_d, hi6_d, lo3_d, hi3_d;
  logic [48:0]        lo6_q, hi6_q, lo3_q, hi3_q;
  logic [49:0]        s5_m5_q, s5_m2_q;

  // Stage 6
  logic [63:0]        prod6_d, prod3_d, prod6_q, prod3_q;
  logic [49:0]        s6_m5_q, s6_m2_q;

  // Stage 7
  logic [63:0]        m5x, m2x, p4x;
  logic [63:0]        v2_d, v1a_d, v2_q, v1a_q;

  // Stage 8
  logic [63:0]        xb;
  logic [47:0]        xlo_d, xhi_d, xlo_q, xhi_q;
  logic [20:0]        pr;
  logic [63:0]        npre_d, npre_q;

  // Stage 9
  logic [63:0]        prodp1;
  logic [30:0]        den_d, den9_q, den10_q;
  logic [43:0]        nlo_d, nhi_d, nlo_q, nhi_q;

  // Stage 10
  logic [63:0]        num_d, num_q;
  logic               zero_q;

  always_comb begin
    v1p = $signed(in_i.tf) - TfOffset;
    sqf = v1p * v1p;
    m5_d = v1p * $signed(coef_i.p5);
    m2_d = v1p * $signed(coef_i.p2);
    t5 = {in_i.tf[29:0], 2'b00} + in_i.tf + 32'd128;
    tc = $signed(t5[31:8]);
    if (tc > 24'sd32767) begin
      temp_d = 16'h7fff;
    end else if (tc < -24'sd32768) begin
      temp_d = 16'h8000;
    end else begin
      temp_d = tc[15:0];
    end

    lo6_d = $signed({1'b0, s4_sq_q[31:0]}) * $signed(coef_i.p6);
    hi6_d = $signed({1'b0, s4_sq_q[63:32]}) * $signed(coef_i.p6);
    lo3_d = $signed({1'b0, s4_sq_q[31:0]}) * $signed(coef_i.p3);
    hi3_d = $signed({1'b0, s4_sq_q[63:32]}) * $signed(coef_i.p3);

    prod6_d = {{15{lo6_q[48]}}, lo6_q} + {hi6_q[31:0], 32'b0};
    prod3_d = {{15{lo3_q[48]}}, lo3_q} + {hi3_q[31:0], 32'b0};

    m5x   = {{14{s6_m5_q[49]}}, s6_m5_q};
    m2x   = {{14{s6_m2_q[49]}}, s6_m2_q};
    p4x   = {{48{coef_i.p4[15]}}, coef_i.p4};
    v2_d  = prod6_q + {m5x[46:0], 17'b0} + {p4x[28:0], 35'b0};
    v1a_d = {{8{prod3_q[63]}}, prod3_q[63:8]} + {m2x[51:0], 12'b0};

    xb     = v1a_q + P1Bias;
    xlo_d  = xb[31:0] * coef_i.p1;
    xhi_d  = xb[63:32] * coef_i.p1;
    pr     = PBase - {1'b0, rp_q[3]};
    npre_d = {12'b0, pr, 31'b0} - v2_q;

    prodp1 = {16'b0, xlo_q} + {xhi_q[31:0], 32'b0};
    den_d  = prodp1[63:33];
    nlo_d  = npre_q[31:0] * NumScale;
    nhi_d  = npre_q[63:32] * NumScale;

    num_d = {20'b0, nlo_q} + {nhi_q[31:0], 32'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_sq_q <= sqf[63:0];
      s4_m5_q <= m5_d;
      s4_m2_q <= m2_d;
      temp_q[0] <= temp_d;
      for (int k = 1; k < 7; k++) temp_q[k] <= temp_q[k-1];
      rp_q[0] <= in_i.raw_pressure;
      for (int k = 1; k < 4; k++) rp_q[k] <= rp_q[k-1];

      lo6_q <= lo6_d;
      hi6_q <= hi6_d;
      lo3_q <= lo3_d;
      hi3_q <= hi3_d;
      s5_m5_q <= s4_m5_q;
      s5_m2_q <= s4_m2_q;

      prod6_q <= prod6_d;
      prod3_q <= prod3_d;
      s6_m5_q <= s5_m5_q;
      s6_m2_q <= s5_m2_q;

      v2_q  <= v2_d;
      v1a_q <= v1a_d;

      xlo_q  <= xlo_d;
      xhi_q  <= xhi_d;
      npre_q <= npre_d;

      den9_q <= den_d;
      nlo_q  <= nlo_d;
      nhi_q  <= nhi_d;

      num_q   <= num_d;
      den10_q <= den9_q;
      zero_q  <= (den9_q == '0);
    end
  end

  assign out_valid_o = vld_q[6];
  assign out_o.num   = num_q;
  assign out_o.den   = den10_q;
  assign out_o.zero  = zero_q;
  assign out_o.temp  = temp_q[6];

endmodule

// File: src/ptc_div.sv
// ----------------------------------------------------------------------------
// ptc_div
// Pipelined signed restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ptc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              in_valid_i,
  input  ptc_pkg::div_in_t  in_i,
  output logic              out_valid_o,
  output ptc_pkg::div_out_t out_o
);
  import ptc_pkg::*;

  typedef struct packed {
    logic [30:0] rem;
    logic [63:0] dq;
    logic [30:0] ad;
    logic        neg;
    logic        zero;
    logic [15:0] temp;
  } div_stage_t;

  div_stage_t      st_d [DivBits+1];
  div_stage_t      st_q [DivBits+1];
  logic [31:0]     trial [DivBits];
  logic [31:0]     diff  [DivBits];
  logic [DivBits:0] vld_q;

  always_comb begin
    st_d[0].rem  = '0;
    st_d[0].dq   = in_i.num[63] ? (64'd0 - in_i.num) : in_i.num;
    st_d[0].ad   = in_i.den[30] ? (31'd0 - in_i.den) : in_i.den;
    st_d[0].neg  = in_i.num[63] ^ in_i.den[30];
    st_d[0].zero = in_i.zero;
    st_d[0].temp = in_i.temp;
    // The dividend shifts out at the top while quotient bits enter at the bottom.
    for (int k = 0; k < DivBits; k++) begin
      trial[k]   = {st_q[k].rem, st_q[k].dq[63]};
      diff[k]    = trial[k] - {1'b0, st_q[k].ad};
      st_d[k+1]  = st_q[k];
      if (trial[k] >= {1'b0, st_q[k].ad}) begin
        st_d[k+1].rem = diff[k][30:0];
        st_d[k+1].dq  = {st_q[k].dq[62:0], 1'b1};
      end else begin
        st_d[k+1].rem = trial[k][30:0];
        st_d[k+1].dq  = {st_q[k].dq[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DivBits-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= DivBits; k++) st_q[k] <= st_d[k];
    end
  end

  assign out_valid_o = vld_q[DivBits];
  assign out_o.dq    = st_q[DivBits].dq;
  assign out_o.neg   = st_q[DivBits].neg;
  assign out_o.zero  = st_q[DivBits].zero;
  assign out_o.temp  = st_q[DivBits].temp;

endmodule

// File: src/ptc_post.sv
// ----------------------------------------------------------------------------
// ptc_post
// Pressure correction after the division, saturation and output register.
// ----------------------------------------------------------------------------
module ptc_post (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  ptc_pkg::coef_t    coef_i,
  input  logic              in_valid_i,
  input  ptc_pkg::div_out_t in_i,
  output logic              out_valid_o,
  output logic [15:0]       temperature_o,
  output logic [31:0]       pressure_o,
  output logic              pressure_valid_o
);
  import ptc_pkg::*;

  logic [5:0]  vld_q;
  logic [15:0] temp_q [6];
  logic        zero_q [5];
  logic [63:0] q_q [4];

  logic [31:0] al, ah;
  logic [63:0] alal_d, alah_full, alal_q;
  logic [30:0] alah_q;
  logic signed [48:0] ql8_d, qh8_d;
  logic [48:0] ql8_q, qh8_q;
  logic [63:0] aa_d, aa_q, m8_d, m8_q, m8b_q;
  logic signed [48:0] lo9_d, hi9_d;
  logic [48:0] lo9_q, hi9_q;
  logic [63:0] m9, sum_d, sum_q;
  logic [63:0] p7x, ps;
  logic [31:0] press_d, press_q;
  logic        pv_q;

  always_comb begin
    al        = q_q[0][44:13];
    ah        = {{13{q_q[0][63]}}, q_q[0][63:45]};
    alal_d    = al * al;
    alah_full = al * ah;
    ql8_d     = $signed({1'b0, q_q[0][31:0]}) * $signed(coef_i.p8);
    qh8_d     = $signed({1'b0, q_q[0][63:32]}) * $signed(coef_i.p8);

    aa_d = alal_q + {alah_q, 33'b0};
    m8_d = {{15{ql8_q[48]}}, ql8_q} + {qh8_q[31:0], 32'b0};

    lo9_d = $signed({1'b0, aa_q[31:0]}) * $signed(coef_i.p9);
    hi9_d = $signed({1'b0, aa_q[63:32]}) * $signed(coef_i.p9);

    m9    = {{15{lo9_q[48]}}, lo9_q} + {hi9_q[31:0], 32'b0};
    sum_d = q_q[3] + {{25{m9[63]}}, m9[63:25]} + {{19{m8b_q[63]}}, m8b_q[63:19]};

    p7x = {{48{coef_i.p7[15]}}, coef_i.p7};
    ps  = {{8{sum_q[63]}}, sum_q[63:8]} + {p7x[59:0], 4'b0};
    if (zero_q[4] || ps[63]) begin
      press_d = '0;
    end else if (ps[63:32] != '0) begin
      press_d = '1;
    end else begin
      press_d = ps[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q[0] <= in_i.neg ? (64'd0 - in_i.dq) : in_i.dq;
      for (int k = 1; k < 4; k++) q_q[k] <= q_q[k-1];
      temp_q[0] <= in_i.temp;
      for (int k = 1; k < 6; k++) temp_q[k] <= temp_q[k-1];
      zero_q[0] <= in_i.zero;
      for (int k = 1; k < 5; k++) zero_q[k] <= zero_q[k-1];

      alal_q <= alal_d;
      alah_q <= alah_full[30:0];
      ql8_q  <= ql8_d;
      qh8_q  <= qh8_d;

      aa_q <= aa_d;
      m8_q <= m8_d;

      lo9_q <= lo9_d;
      hi9_q <= hi9_d;
      m8b_q <= m8_q;

      sum_q <= sum_d;

      press_q <= press_d;
      pv_q    <= !zero_q[4];
    end
  end

  assign out_valid_o      = vld_q[5];
  assign temperature_o    = temp_q[5];
  assign pressure_o       = press_q;
  assign pressure_valid_o = pv_q;

endmodule

// File: src/pressure_temperature_compensation.sv
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// Integer barometric compensation of raw temperature and pressure samples.
// ----------------------------------------------------------------------------
// Channel  Dir  Carries
// cfg_i    in   register index and 48-bit coefficient word
// in_i     in   raw_temperature, raw_pressure
// out_o    out  temperature_centidegrees, pressure_q24_8, pressure_valid
//
// One request is taken per cycle unless the output stalls; each result passes
// the 64 stages of the divider and the multiply and add stages around it.
// Reset clears the coefficients and all valid bits; no clearing pass is needed.
// A stalled output freezes the whole pipe; the first stage still takes a
// request when it is empty. Configuration is always ready.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation (
  input  logic  clk_i,
  input  logic  rst_ni,
  ptc_cfg_if.sink   cfg_i,
  ptc_in_if.sink    in_i,
  ptc_out_if.source out_o
);
  import ptc_pkg::*;

  logic [47:0] reg_q [4];
  coef_t       coef;
  logic        en;
  logic        out_valid;

  logic    tf_valid, prep_valid, div_valid;
  tf_t     tf_data;
  div_in_t prep_data;
  div_out_t div_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) reg_q[k] <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegTempCoef:  reg_q[0] <= cfg_i.data;
        RegPressLow:  reg_q[1] <= cfg_i.data;
        RegPressMid:  reg_q[2] <= cfg_i.data;
        RegPressHigh: reg_q[3] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign coef.t1 = reg_q[0][15:0];
  assign coef.t2 = reg_q[0][31:16];
  assign coef.t3 = reg_q[0][47:32];
  assign coef.p1 = reg_q[1][15:0];
  assign coef.p2 = reg_q[1][31:16];
  assign coef.p3 = reg_q[1][47:32];
  assign coef.p4 = reg_q[2][15:0];
  assign coef.p5 = reg_q[2][31:16];
  assign coef.p6 = reg_q[2][47:32];
  assign coef.p7 = reg_q[3][15:0];
  assign coef.p8 = reg_q[3][31:16];
  assign coef.p9 = reg_q[3][47:32];

  assign en = !out_valid || out_o.ready;

  ptc_temp u_temp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (en),
    .coef_i            (coef),
    .in_valid_i        (in_i.valid),
    .raw_temperature_i (in_i.raw_temperature),
    .raw_pressure_i    (in_i.raw_pressure),
    .in_ready_o        (in_i.ready),
    .out_valid_o       (tf_valid),
    .out_o             (tf_data)
  );

  ptc_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .coef_i      (coef),
    .in_valid_i  (tf_valid),
    .in_i        (tf_data),
    .out_valid_o (prep_valid),
    .out_o       (prep_data)
  );

  ptc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (prep_valid),
    .in_i        (prep_data),
    .out_valid_o (div_valid),
    .out_o       (div_data)
  );

  ptc_post u_post (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (en),
    .coef_i           (coef),
    .in_valid_i       (div_valid),
    .in_i             (div_data),
    .out_valid_o      (out_valid),
    .temperature_o    (out_o.temperature_centidegrees),
    .pressure_o       (out_o.pressure_q24_8),
    .pressure_valid_o (out_o.pressure_valid)
  );

  assign out_o.valid = out_valid;

  // An invalid pressure always reads as zero.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_o.pressure_valid |-> out_o.pressure_q24_8 == '0)
    else $error("invalid pressure is not zero");

  // A taken result never blocks the input.
  a_ready_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.ready |-> in_i.ready)
    else $error("input stalled while output was ready");

  // During a stall the middle of the pipe holds its requests.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(prep_valid) && $stable(div_valid))
    else $error("pipe moved during a stall");

endmodule
